### rtl/cjt_pkg.sv
// Shared definitions for the cubic joint trajectory generator.
// Widths, reset values, register indexes and the shared unit's request type.
// Used by cjt_unit and cubic_joint_trajectory_generator_top; depends on nothing.
`default_nettype none

package cjt_pkg;

  localparam int ANGLE_W        = 8;
  localparam int TIME_W         = 8;
  localparam int IDX_W          = 6;
  localparam int JOINTS         = 4;
  localparam int JOINT_SEL_W    = 2;
  localparam int ANGLE_MAX      = 180;
  localparam int TOTAL_TIME_RST = 100;
  localparam int TIME_STEP_RST  = 3;
  localparam int MAX_POINTS_DEF = 64;

  // Shared unit: one 24 x 16 multiplier and one 32-bit compare/subtract.
  localparam int UNIT_W  = 32;
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 16;
  localparam int DEN_W   = 24;
  localparam int QUOT_W  = 8;
  localparam int QSTEP_W = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_MUL,
    OP_SUB
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } unit_req_t;

endpackage

`default_nettype wire

### rtl/cjt_unit.sv
// Shared arithmetic unit: a multiplier and a restoring-division step.
// Results are registered; a hold request keeps the last result.
// Depends on cjt_pkg.
`default_nettype none

module cjt_unit (
  input  wire logic                       clk,
  input  wire cjt_pkg::unit_req_t         req,
  output logic [cjt_pkg::UNIT_W-1:0]      res,
  output logic                            qbit
);

  localparam int UnitW = cjt_pkg::UNIT_W;
  localparam int ProdW = cjt_pkg::MUL_A_W + cjt_pkg::MUL_B_W;

  logic [UnitW-1:0] res_r, res_nxt;
  logic             qbit_r, qbit_nxt;
  logic [ProdW-1:0] prod;
  logic             ge;

  always_comb begin
    prod     = req.a[cjt_pkg::MUL_A_W-1:0] * req.b[cjt_pkg::MUL_B_W-1:0];
    ge       = (req.a >= req.b);
    res_nxt  = res_r;
    qbit_nxt = qbit_r;
    unique case (req.op)
      cjt_pkg::OP_MUL: begin
        res_nxt = prod[UnitW-1:0];
      end
      cjt_pkg::OP_SUB: begin
        // One quotient bit: subtract the shifted divisor when it fits.
        res_nxt  = ge ? (req.a - req.b) : req.a;
        qbit_nxt = ge;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    qbit_r <= qbit_nxt;
  end

  assign res  = res_r;
  assign qbit = qbit_r;

endmodule

`default_nettype wire

### rtl/cubic_joint_trajectory_generator_top.sv
// Cubic joint trajectory generator: sequencer around one shared multiply/divide unit.
// Each point forms the shape factor, then for each of the four joints one multiply,
// eight divide steps and a fix-up; with a total time of zero a point skips the
// division and repeats the start angles. One move at a time.
// Reset (synchronous, rst_n low): angles 0, 0, 0, 180, total time 100, step 3.
`default_nettype none

module cubic_joint_trajectory_generator_top #(
  parameter int MAX_POINTS = cjt_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cjt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cjt_pkg::TIME_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [cjt_pkg::ANGLE_W-1:0]       in_base_target,
  input  wire logic [cjt_pkg::ANGLE_W-1:0]       in_upper_arm_target,
  input  wire logic [cjt_pkg::ANGLE_W-1:0]       in_forearm_target,
  input  wire logic [cjt_pkg::ANGLE_W-1:0]       in_gripper_target,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [cjt_pkg::ANGLE_W-1:0]            out_base_deg,
  output logic [cjt_pkg::ANGLE_W-1:0]            out_upper_arm_angle,
  output logic [cjt_pkg::ANGLE_W-1:0]            out_forearm_deg,
  output logic [cjt_pkg::ANGLE_W-1:0]            out_gripper_angle,
  output logic [cjt_pkg::IDX_W-1:0]              out_point_index,
  output logic                                   out_last_point
);

  localparam int KW     = $clog2(MAX_POINTS);
  localparam int AngW   = cjt_pkg::ANGLE_W;
  localparam int TimeW  = cjt_pkg::TIME_W;
  localparam int UnitW  = cjt_pkg::UNIT_W;
  localparam int IdxW   = cjt_pkg::IDX_W;
  localparam int Joints = cjt_pkg::JOINTS;
  localparam int JSelW  = cjt_pkg::JOINT_SEL_W;
  localparam int DenW   = cjt_pkg::DEN_W;
  localparam int QuotW  = cjt_pkg::QUOT_W;
  localparam int QStepW = cjt_pkg::QSTEP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUBE_A,
    S_CUBE_B,
    S_CUBE_C,
    S_PT,
    S_SH_A,
    S_SH_B,
    S_JM,
    S_DIV,
    S_JF,
    S_EMIT
  } state_t;

  // Configuration registers.
  logic [TimeW-1:0] total_time_r;
  logic [TimeW-1:0] time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_time_r <= TimeW'(cjt_pkg::TOTAL_TIME_RST);
      time_step_r  <= TimeW'(cjt_pkg::TIME_STEP_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cjt_pkg::REG_TOTAL_TIME: total_time_r <= cfg_wdata;
        cjt_pkg::REG_TIME_STEP:  time_step_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  state_t            state_r, state_nxt;
  logic [AngW-1:0]   joint_r [Joints];
  logic [AngW-1:0]   joint_nxt [Joints];
  logic [AngW-1:0]   tgt_r [Joints];
  logic [AngW-1:0]   tgt_nxt [Joints];
  logic [AngW-1:0]   ang_r [Joints];
  logic [AngW-1:0]   ang_nxt [Joints];
  logic [KW-1:0]     k_r, k_nxt;
  logic [TimeW-1:0]  t_r, t_nxt;
  logic [DenW-1:0]   den_r, den_nxt;
  logic [DenW-1:0]   shape_r, shape_nxt;
  logic [JSelW-1:0]  j_r, j_nxt;
  logic [QStepW-1:0] i_r, i_nxt;
  logic [QuotW-1:0]  q_r, q_nxt;
  logic              neg_r, neg_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;

  cjt_pkg::unit_req_t req;
  logic [UnitW-1:0]   unit_res;
  logic               unit_bit;

  cjt_unit u_unit (
    .clk  (clk),
    .req  (req),
    .res  (unit_res),
    .qbit (unit_bit)
  );

  logic [AngW:0]     diff;
  logic [AngW-1:0]   diff_mag;
  logic [TimeW:0]    t_sum;
  logic              last_pt;
  logic [TimeW+1:0]  shape_fac;
  logic [QuotW-1:0]  quot;
  logic [QuotW+1:0]  q_signed;
  logic [AngW+2:0]   v;
  logic [AngW-1:0]   v_clamped;

  always_comb begin
    state_nxt     = state_r;
    joint_nxt     = joint_r;
    tgt_nxt       = tgt_r;
    ang_nxt       = ang_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    den_nxt       = den_r;
    shape_nxt     = shape_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    q_nxt         = q_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;

    req.op = cjt_pkg::OP_HOLD;
    req.a  = '0;
    req.b  = '0;

    diff      = {1'b0, tgt_r[j_r]} - {1'b0, joint_r[j_r]};
    diff_mag  = diff[AngW] ? AngW'(-diff) : diff[AngW-1:0];
    t_sum     = {1'b0, t_r} + {1'b0, time_step_r};
    last_pt   = (k_r == KW'(MAX_POINTS - 1)) || (t_sum > {1'b0, total_time_r});
    // 3T - 2t, never negative while t <= T.
    shape_fac = {2'b00, total_time_r} + {1'b0, total_time_r, 1'b0} - {1'b0, t_r, 1'b0};
    quot      = {q_r[QuotW-2:0], unit_bit};
    // Floor division: a negative quotient with a remainder steps down by one.
    q_signed  = neg_r ? ((QuotW+2)'(0) - {2'b00, quot} - {{(QuotW+1){1'b0}}, |unit_res})
                      : {2'b00, quot};
    v         = {3'b000, joint_r[j_r]} + {q_signed[QuotW+1], q_signed};
    if (v[AngW+2]) begin
      v_clamped = '0;
    end else if (v > (AngW+3)'(cjt_pkg::ANGLE_MAX)) begin
      v_clamped = AngW'(cjt_pkg::ANGLE_MAX);
    end else begin
      v_clamped = v[AngW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt[0] = in_base_target;
          tgt_nxt[1] = in_upper_arm_target;
          tgt_nxt[2] = in_forearm_target;
          tgt_nxt[3] = in_gripper_target;
          k_nxt      = '0;
          t_nxt      = '0;
          state_nxt  = S_CUBE_A;
        end
      end
      S_CUBE_A: begin
        req.op    = cjt_pkg::OP_MUL;
        req.a     = UnitW'(total_time_r);
        req.b     = UnitW'(total_time_r);
        state_nxt = S_CUBE_B;
      end
      S_CUBE_B: begin
        req.op    = cjt_pkg::OP_MUL;
        req.a     = unit_res;
        req.b     = UnitW'(total_time_r);
        state_nxt = S_CUBE_C;
      end
      S_CUBE_C: begin
        den_nxt   = unit_res[DenW-1:0];
        state_nxt = S_PT;
      end
      S_PT: begin
        if (total_time_r == '0) begin
          // A zero-length move repeats the start angles without dividing.
          ang_nxt       = joint_r;
          last_nxt      = last_pt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          req.op    = cjt_pkg::OP_MUL;
          req.a     = UnitW'(t_r);
          req.b     = UnitW'(t_r);
          state_nxt = S_SH_A;
        end
      end
      S_SH_A: begin
        req.op    = cjt_pkg::OP_MUL;
        req.a     = unit_res;
        req.b     = UnitW'(shape_fac);
        state_nxt = S_SH_B;
      end
      S_SH_B: begin
        shape_nxt = unit_res[DenW-1:0];
        j_nxt     = '0;
        state_nxt = S_JM;
      end
      S_JM: begin
        req.op    = cjt_pkg::OP_MUL;
        req.a     = UnitW'(shape_r);
        req.b     = UnitW'(diff_mag);
        neg_nxt   = diff[AngW];
        i_nxt     = '1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // The product is below 256 times the divisor, so eight steps suffice.
        req.op = cjt_pkg::OP_SUB;
        req.a  = unit_res;
        req.b  = UnitW'(den_r) << i_r;
        if (i_r != '1) begin
          q_nxt = {q_r[QuotW-2:0], unit_bit};
        end
        if (i_r == '0) begin
          state_nxt = S_JF;
        end else begin
          i_nxt = i_r - 1'b1;
        end
      end
      S_JF: begin
        ang_nxt[j_r] = v_clamped;
        if (j_r == JSelW'(Joints - 1)) begin
          last_nxt      = last_pt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_JM;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            // The last point becomes the start of the next move.
            joint_nxt = ang_r;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            t_nxt     = t_sum[TimeW-1:0];
            state_nxt = S_PT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      joint_r[0]  <= '0;
      joint_r[1]  <= '0;
      joint_r[2]  <= '0;
      joint_r[3]  <= AngW'(cjt_pkg::ANGLE_MAX);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      joint_r     <= joint_nxt;
    end
    tgt_r   <= tgt_nxt;
    ang_r   <= ang_nxt;
    k_r     <= k_nxt;
    t_r     <= t_nxt;
    den_r   <= den_nxt;
    shape_r <= shape_nxt;
    j_r     <= j_nxt;
    i_r     <= i_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    last_r  <= last_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_base_deg        = ang_r[0];
  assign out_upper_arm_angle = ang_r[1];
  assign out_forearm_deg     = ang_r[2];
  assign out_gripper_angle   = ang_r[3];
  assign out_point_index     = IdxW'(k_r);
  assign out_last_point      = last_r;

endmodule

`default_nettype wire

### tb/cubic_joint_trajectory_generator_top_tb.sv
// Self-checking testbench for cubic_joint_trajectory_generator_top: move commands in,
// clamped cubic trajectory points out, checked against an in-bench predictor.
// Depends on cjt_pkg and the top-level RTL only.
`default_nettype none

module cubic_joint_trajectory_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_W        = cjt_pkg::ANGLE_W;
  localparam int IDX_W          = cjt_pkg::IDX_W;
  localparam int TIME_W         = cjt_pkg::TIME_W;
  localparam int CFG_IDX_W      = cjt_pkg::CFG_IDX_W;
  localparam int JOINTS         = cjt_pkg::JOINTS;
  localparam int ANGLE_MAX      = cjt_pkg::ANGLE_MAX;
  localparam int MAX_POINTS_DEF = cjt_pkg::MAX_POINTS_DEF;
  localparam int TOTAL_TIME_RST = cjt_pkg::TOTAL_TIME_RST;
  localparam int TIME_STEP_RST  = cjt_pkg::TIME_STEP_RST;

  localparam int RUN_LIMIT = 10_000_000;
  localparam int HOLD_LEN  = 2500;

  typedef struct packed {
    logic [ANGLE_W-1:0] base;
    logic [ANGLE_W-1:0] upper_arm;
    logic [ANGLE_W-1:0] forearm;
    logic [ANGLE_W-1:0] gripper;
  } move_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] base;
    logic [ANGLE_W-1:0] upper_arm;
    logic [ANGLE_W-1:0] forearm;
    logic [ANGLE_W-1:0] gripper;
    logic [IDX_W-1:0]   index;
    logic               last;
  } point_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = cjt_pkg::REG_TOTAL_TIME;
  logic [TIME_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ANGLE_W-1:0]   in_base_target = '0;
  logic [ANGLE_W-1:0]   in_upper_arm_target = '0;
  logic [ANGLE_W-1:0]   in_forearm_target = '0;
  logic [ANGLE_W-1:0]   in_gripper_target = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ANGLE_W-1:0]   out_base_deg;
  logic [ANGLE_W-1:0]   out_upper_arm_angle;
  logic [ANGLE_W-1:0]   out_forearm_deg;
  logic [ANGLE_W-1:0]   out_gripper_angle;
  logic [IDX_W-1:0]     out_point_index;
  logic                 out_last_point;

  cubic_joint_trajectory_generator_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_base_target      (in_base_target),
    .in_upper_arm_target (in_upper_arm_target),
    .in_forearm_target   (in_forearm_target),
    .in_gripper_target   (in_gripper_target),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_base_deg        (out_base_deg),
    .out_upper_arm_angle (out_upper_arm_angle),
    .out_forearm_deg     (out_forearm_deg),
    .out_gripper_angle   (out_gripper_angle),
    .out_point_index     (out_point_index),
    .out_last_point      (out_last_point)
  );

  // Predictor state: commanded joint angles and the register copies.
  logic [ANGLE_W-1:0] joint_pos [JOINTS] = '{8'd0, 8'd0, 8'd0, 8'(ANGLE_MAX)};
  int                 span_cfg = TOTAL_TIME_RST;
  int                 step_cfg = TIME_STEP_RST;

  move_t  move_q[$];
  point_t expected_points[$];
  move_t  next_move;
  point_t want;

  int send_idle_pct = 16;
  int recv_idle_pct = 79;
  int mismatch_count = 0;
  int points_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_trigger = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [ANGLE_W-1:0] interp_angle(longint start, longint goal, longint t,
                                                        longint span);
    longint v, shape, num, den, q;
    v = start;
    if (span > 0) begin
      shape = t * t * (3 * span - 2 * t);
      num   = (goal - start) * shape;
      den   = span * span * span;
      q     = num / den;
      // Round toward minus infinity, not toward zero.
      if (num % den != 0 && num < 0) q = q - 1;
      v = start + q;
    end
    if (v < 0) v = 0;
    if (v > ANGLE_MAX) v = ANGLE_MAX;
    return v[ANGLE_W-1:0];
  endfunction

  task automatic predict_trajectory(input move_t mv);
    logic [ANGLE_W-1:0] goal [JOINTS];
    logic [ANGLE_W-1:0] pos [JOINTS];
    longint t;
    int count;
    point_t pt;
    goal = '{mv.base, mv.upper_arm, mv.forearm, mv.gripper};
    pos = joint_pos;
    t = 0;
    count = 0;
    while (count < MAX_POINTS_DEF && t <= span_cfg) begin
      for (int j = 0; j < JOINTS; j++)
        pos[j] = interp_angle(joint_pos[j], goal[j], t, span_cfg);
      pt.base      = pos[0];
      pt.upper_arm = pos[1];
      pt.forearm   = pos[2];
      pt.gripper   = pos[3];
      pt.index     = count[IDX_W-1:0];
      pt.last      = (count + 1 == MAX_POINTS_DEF) || (t + step_cfg > span_cfg);
      expected_points.push_back(pt);
      count++;
      t += step_cfg;
    end
    // The last point emitted is the start of the next move.
    joint_pos = pos;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch on result %0d: %s expected %0d, got %0d",
               points_seen, field, want_v, got_v);
  endtask

  function automatic logic [ANGLE_W-1:0] rand_angle();
    if ($urandom_range(0, 9) < 3) return ANGLE_W'($urandom_range(0, 255));
    return ANGLE_W'($urandom_range(0, ANGLE_MAX));
  endfunction

  function automatic void add_move(int b, int u, int f, int g);
    move_q.push_back({ANGLE_W'(b), ANGLE_W'(u), ANGLE_W'(f), ANGLE_W'(g)});
  endfunction

  // Sampled on the falling edge, after the driver and the monitor have settled.
  task automatic wait_drained();
    while (move_q.size() != 0 || in_valid || expected_points.size() != 0) @(negedge clk);
  endtask

  // Registers only change while the block is idle, so the predictor copy is updated here.
  task automatic configure(input int span, input int step);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cjt_pkg::REG_TOTAL_TIME;
    cfg_wdata <= TIME_W'(span);
    @(posedge clk);
    cfg_index <= cjt_pkg::REG_TIME_STEP;
    cfg_wdata <= TIME_W'(step);
    @(posedge clk);
    cfg_we   <= 1'b0;
    span_cfg = span;
    step_cfg = step;
  endtask

  // Input side: a transfer completes when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_trajectory({in_base_target, in_upper_arm_target, in_forearm_target,
                            in_gripper_target});
      if (!in_valid || !in_stall) begin
        if (move_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_move = move_q.pop_front();
          in_valid            <= 1'b1;
          in_base_target      <= next_move.base;
          in_upper_arm_target <= next_move.upper_arm;
          in_forearm_target   <= next_move.forearm;
          in_gripper_target   <= next_move.gripper;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_trigger) hold_left <= HOLD_LEN;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result side: check every transfer against the oldest expected point.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point_index with no result expected", 0, out_point_index);
        end else begin
          want = expected_points.pop_front();
          if (out_base_deg !== want.base)
            report_mismatch("base_deg", want.base, out_base_deg);
          if (out_upper_arm_angle !== want.upper_arm)
            report_mismatch("upper_arm_angle", want.upper_arm, out_upper_arm_angle);
          if (out_forearm_deg !== want.forearm)
            report_mismatch("forearm_deg", want.forearm, out_forearm_deg);
          if (out_gripper_angle !== want.gripper)
            report_mismatch("gripper_angle", want.gripper, out_gripper_angle);
          if (out_point_index !== want.index)
            report_mismatch("point_index", want.index, out_point_index);
          if (out_last_point !== want.last)
            report_mismatch("last_point", want.last, out_last_point);
        end
        points_seen++;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL cubic_joint_trajectory_generator_top");
      $finish;
    end
  end

  initial begin
    int span, step, mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full range, above-range targets, moves down from 180.
    add_move(0, 0, 0, 0);
    add_move(180, 180, 180, 180);
    add_move(255, 255, 255, 255);
    add_move(0, 0, 0, 0);
    add_move(181, 200, 90, 45);
    add_move(1, 179, 128, 127);
    add_move(90, 0, 180, 255);
    add_move(170, 85, 60, 15);

    // Zero total time: one point holding the start angles.
    configure(0, 5);
    add_move(10, 20, 30, 40);
    add_move(255, 0, 255, 0);
    // Zero step: a full run of identical points.
    configure(255, 0);
    add_move(200, 100, 50, 25);
    configure(255, 255);
    add_move(0, 180, 90, 255);
    add_move(180, 0, 45, 3);
    configure(1, 1);
    add_move(77, 180, 0, 200);
    add_move(0, 255, 180, 1);
    // Step of one over the longest time hits the point cap.
    configure(255, 1);
    add_move(180, 0, 170, 90);
    configure(1, 255);
    add_move(30, 60, 120, 150);
    configure(0, 0);
    add_move(0, 0, 0, 0);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 16;
      end
      if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mode = $urandom_range(0, 7);
      span = $urandom_range(0, 255);
      if (mode == 0) begin
        step = $urandom_range(0, 3);
      end else if (mode == 1) begin
        span = $urandom_range(0, 1) ? 255 : 0;
        step = $urandom_range(0, 255);
      end else begin
        // Mostly short runs to keep the simulation time down.
        step = $urandom_range(span / 10 + 1, 255);
      end
      configure(span, step);
      repeat (30) move_q.push_back({rand_angle(), rand_angle(), rand_angle(), rand_angle()});
      if (ph == 2) begin
        hold_trigger <= 1'b1;
        @(posedge clk);
        hold_trigger <= 1'b0;
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS cubic_joint_trajectory_generator_top");
    end else begin
      $display("FAIL cubic_joint_trajectory_generator_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
